/* design/lzss_pkg.sv */
// Shared types and format constants of the LZSS stream decoder.
// Depends on nothing; the decoder top level uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lzss_pkg;

	// Token format.
	localparam int unsigned FLAG_BITS = 8;   // tokens announced by one flag byte
	localparam int unsigned LEN_BIAS  = 3;   // shortest reference length
	localparam int unsigned LEN_W     = 5;   // holds 3 .. 18
	localparam int unsigned DIST_W    = 12;  // distance minus one
	localparam int unsigned COUNT_W   = 24;  // decoded length and byte count

	// Header byte indices of the low, middle and top bytes of the decoded length.
	localparam logic [1:0] HDR_LEN_LO  = 2'd1;
	localparam logic [1:0] HDR_LEN_MID = 2'd2;
	localparam logic [1:0] HDR_LEN_HI  = 2'd3;

	// One result word as it sits in the output register.
	typedef struct packed {
		logic [7:0]         data_b;
		logic               has_data;
		logic               run_end;
		logic               finished;
		logic [COUNT_W-1:0] total;
	} out_word_t;

endpackage

`default_nettype wire

/* design/lzss_ram.sv */
// Generic single-clock RAM: one write port and one read port with registered read.
// Read during a write to the same address returns the old contents. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lzss_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* design/lzss_stream_decoder_top.sv */
// LZSS (LZ10 style) stream decoder: header, flag and token parsing around a history RAM.
// Depends on lzss_pkg (types, format constants) and lzss_ram (history window).
`timescale 1ns / 1ps
`default_nettype none

// Usage.
// Packed bytes enter on the slave stream, one per word; s_tlast marks the last byte of a
// compressed stream. Every input word yields one or more result words on the master
// stream; m_tlast marks the last result of each input word. A header, flag or skipped
// byte, or the first byte of a back reference, yields one empty word (has_data low). A
// literal yields one decoded byte, which is in the output register the cycle after the
// input word is taken. The second byte of a back reference starts a copy out of the
// history window: one read issued and one copied byte delivered per cycle while the
// output register is free, each byte passing through the RAM's read register first, 3
// to 18 bytes in all, fewer where the decoded length runs out. No input word is taken
// during the copy; other words are taken one per cycle while the output is free. The
// history RAM's single read port and registered read set the copy rate, with a
// forwarding register covering a read of the entry being written in the same cycle
// (distance one). After reset the block sweeps zeros into the 4096-entry window, one
// entry per cycle, with s_tready low. When the receiver stalls, the output register
// holds its word, the copy pauses with its pending RAM data held, and no input is
// taken. The window and its write pointer persist from one stream to the next.
module lzss_stream_decoder_top #(
	parameter int unsigned WINDOW_DEPTH = 4096
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Slave stream: packed bytes.
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] packed_byte
	input  wire logic        s_tlast,   // final_packed
	// Master stream: decoded results.
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [7:0] out_byte, [31:8] produced_total
	output logic      [1:0]  m_tuser,   // [0] has_data, [1] finished
	output logic             m_tlast    // run_end
);

	localparam int unsigned AW      = $clog2(WINDOW_DEPTH);
	localparam int unsigned CW      = lzss_pkg::COUNT_W;
	localparam int unsigned LW      = lzss_pkg::LEN_W;

	localparam logic [2:0] ST_CLEAR   = 3'd0;
	localparam logic [2:0] ST_HEADER  = 3'd1;
	localparam logic [2:0] ST_TOKEN   = 3'd2;
	localparam logic [2:0] ST_REF_LOW = 3'd3;
	localparam logic [2:0] ST_COPY    = 3'd4;
	localparam logic [2:0] ST_DONE    = 3'd5;

	// Control state.
	logic [2:0]                      state_q;
	logic [1:0]                      hidx_q;
	logic [7:0]                      flags_q;
	logic [3:0]                      fpos_q;
	logic [7:0]                      hi_q;
	logic [CW-1:0]                   rem_q;
	logic [CW-1:0]                   prod_q;
	logic [AW-1:0]                   wp_q;
	logic [AW-1:0]                   clr_q;
	logic [LW-1:0]                   cnt_q;
	logic [lzss_pkg::DIST_W-1:0]     dist_q;
	logic                            last_q;
	logic                            rdv_q;
	logic                            fwd_q;
	logic [7:0]                      fwd_data_q;
	logic                            ovld_q;
	lzss_pkg::out_word_t             oword_q;

	// Datapath signals.
	logic                            out_free;
	logic                            in_acc;
	logic                            consume;
	logic                            issue;
	logic [AW-1:0]                   wp_eff;
	logic [AW-1:0]                   raddr;
	logic [7:0]                      rdata;
	logic [7:0]                      copy_byte;
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [7:0]                      ram_wdata;
	logic [3:0]                      fpos_dec;
	logic                            tok_bit;
	logic                            lit;
	logic [CW-1:0]                   rem_hdr;
	logic [CW-1:0]                   rem_dec;
	logic [CW-1:0]                   prod_inc;
	logic [LW-1:0]                   len_raw;
	logic [LW-1:0]                   len_clamp;
	logic                            emit_empty;
	logic                            empty_fin;
	logic [2:0]                      state_after;

	assign out_free = !ovld_q || m_tready;
	assign s_tready = out_free && (state_q != ST_CLEAR) && (state_q != ST_COPY);
	assign in_acc   = s_tvalid && s_tready;

	// Copy engine: one RAM read in flight at most; data is consumed when the output is free.
	assign consume   = (state_q == ST_COPY) && rdv_q && out_free;
	assign issue     = (state_q == ST_COPY) &&
	                   ((!rdv_q && (cnt_q != '0)) || (consume && (cnt_q > LW'(1))));
	assign wp_eff    = consume ? (wp_q + AW'(1)) : wp_q;
	assign raddr     = wp_eff - AW'(dist_q) - AW'(1);
	assign copy_byte = fwd_q ? fwd_data_q : rdata;

	// Token decode.
	assign fpos_dec = fpos_q - 4'd1;
	assign tok_bit  = flags_q[fpos_dec[2:0]];
	assign lit      = (state_q == ST_TOKEN) && (fpos_q != 4'd0) && !tok_bit;

	assign rem_dec  = rem_q - CW'(1);
	assign prod_inc = prod_q + CW'(1);
	assign len_raw  = LW'(hi_q[7:4]) + LW'(lzss_pkg::LEN_BIAS);
	assign len_clamp = (rem_q < CW'(len_raw)) ? rem_q[LW-1:0] : len_raw;

	always_comb begin
		case (hidx_q)
			lzss_pkg::HDR_LEN_LO:  rem_hdr = {16'd0, s_tdata};
			lzss_pkg::HDR_LEN_MID: rem_hdr = {rem_q[23:16], s_tdata, rem_q[7:0]};
			lzss_pkg::HDR_LEN_HI:  rem_hdr = {s_tdata, rem_q[15:0]};
			default:               rem_hdr = rem_q;
		endcase
	end

	// Empty result words and where the stream goes after a non-copy input word.
	always_comb begin
		emit_empty  = 1'b0;
		empty_fin   = s_tlast;
		state_after = state_q;
		unique case (state_q)
			ST_HEADER: begin
				emit_empty = 1'b1;
				if (hidx_q == lzss_pkg::HDR_LEN_HI) begin
					state_after = (rem_hdr == '0) ? ST_DONE : ST_TOKEN;
				end
				empty_fin = s_tlast || ((hidx_q == lzss_pkg::HDR_LEN_HI) && (rem_hdr == '0));
			end
			ST_TOKEN: begin
				if (fpos_q == 4'd0) begin
					emit_empty = 1'b1;
				end else if (tok_bit) begin
					emit_empty  = 1'b1;
					state_after = ST_REF_LOW;
				end else begin
					state_after = (rem_dec == '0) ? ST_DONE : ST_TOKEN;
				end
			end
			ST_REF_LOW: begin
				state_after = ST_COPY;
			end
			ST_DONE: begin
				emit_empty = 1'b1;
				empty_fin  = 1'b1;
			end
			default: begin
				state_after = state_q;
			end
		endcase
	end

	// History RAM write port: clearing sweep, literals and copied bytes.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = s_tdata;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 8'd0;
		end else if (in_acc && lit) begin
			ram_we = 1'b1;
		end else if (consume) begin
			ram_we    = 1'b1;
			ram_wdata = copy_byte;
		end
	end

	lzss_ram #(
		.WIDTH (8),
		.DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			hidx_q  <= '0;
			flags_q <= '0;
			fpos_q  <= '0;
			hi_q    <= '0;
			rem_q   <= '0;
			prod_q  <= '0;
			wp_q    <= '0;
			clr_q   <= '0;
			cnt_q   <= '0;
			dist_q  <= '0;
			last_q  <= 1'b0;
			rdv_q   <= 1'b0;
			fwd_q   <= 1'b0;
			ovld_q  <= 1'b0;
		end else begin
			// A new word enters the output register, or the held one leaves it.
			if ((in_acc && (lit || emit_empty)) || consume) begin
				ovld_q <= 1'b1;
			end else if (m_tready) begin
				ovld_q <= 1'b0;
			end

			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(WINDOW_DEPTH - 1)) begin
					state_q <= ST_HEADER;
				end
			end

			if (in_acc) begin
				if (lit) begin
					wp_q <= wp_q + AW'(1);
				end

				// The final byte restarts the stream, except a reference low byte,
				// whose copy restarts it when done.
				if (s_tlast && (state_q != ST_REF_LOW)) begin
					state_q <= ST_HEADER;
					hidx_q  <= '0;
					flags_q <= '0;
					fpos_q  <= '0;
					hi_q    <= '0;
					rem_q   <= '0;
					prod_q  <= '0;
				end else begin
					state_q <= state_after;
					unique case (state_q)
						ST_HEADER: begin
							rem_q <= rem_hdr;
							if (hidx_q == lzss_pkg::HDR_LEN_HI) begin
								hidx_q <= '0;
								fpos_q <= '0;
							end else begin
								hidx_q <= hidx_q + 2'd1;
							end
						end
						ST_TOKEN: begin
							if (fpos_q == 4'd0) begin
								flags_q <= s_tdata;
								fpos_q  <= 4'(lzss_pkg::FLAG_BITS);
							end else begin
								fpos_q <= fpos_dec;
								if (tok_bit) begin
									hi_q <= s_tdata;
								end else begin
									rem_q  <= rem_dec;
									prod_q <= prod_inc;
								end
							end
						end
						ST_REF_LOW: begin
							cnt_q  <= len_clamp;
							dist_q <= {hi_q[3:0], s_tdata};
							last_q <= s_tlast;
							rdv_q  <= 1'b0;
							fwd_q  <= 1'b0;
						end
						default: begin
						end
					endcase
				end
			end

			if (state_q == ST_COPY) begin
				if (issue) begin
					rdv_q <= 1'b1;
					fwd_q <= ram_we && (ram_waddr == raddr);
				end else if (consume) begin
					rdv_q <= 1'b0;
				end
				if (consume) begin
					wp_q  <= wp_q + AW'(1);
					cnt_q <= cnt_q - LW'(1);
					if ((cnt_q == LW'(1)) && last_q) begin
						state_q <= ST_HEADER;
						hidx_q  <= '0;
						flags_q <= '0;
						fpos_q  <= '0;
						hi_q    <= '0;
						rem_q   <= '0;
						prod_q  <= '0;
					end else begin
						rem_q  <= rem_dec;
						prod_q <= prod_inc;
						if (cnt_q == LW'(1)) begin
							state_q <= (rem_dec == '0) ? ST_DONE : ST_TOKEN;
						end
					end
				end
			end
		end
	end

	// Output payload and forwarding data need no reset.
	always_ff @(posedge clk) begin
		if (issue) begin
			fwd_data_q <= ram_wdata;
		end
		if (in_acc && lit) begin
			oword_q.data_b   <= s_tdata;
			oword_q.has_data <= 1'b1;
			oword_q.run_end  <= 1'b1;
			oword_q.finished <= s_tlast || (rem_dec == '0);
			oword_q.total    <= prod_inc;
		end else if (in_acc && emit_empty) begin
			oword_q.data_b   <= 8'd0;
			oword_q.has_data <= 1'b0;
			oword_q.run_end  <= 1'b1;
			oword_q.finished <= empty_fin;
			oword_q.total    <= prod_q;
		end else if (consume) begin
			oword_q.data_b   <= copy_byte;
			oword_q.has_data <= 1'b1;
			oword_q.run_end  <= (cnt_q == LW'(1));
			oword_q.finished <= (cnt_q == LW'(1)) && (last_q || (rem_dec == '0));
			oword_q.total    <= prod_inc;
		end
	end

	assign m_tvalid = ovld_q;
	assign m_tdata  = {oword_q.total, oword_q.data_b};
	assign m_tuser  = {oword_q.finished, oword_q.has_data};
	assign m_tlast  = oword_q.run_end;

endmodule

`default_nettype wire

/* tb/tb_lzss_stream_decoder_top.sv */
// Self-checking testbench for the LZSS stream decoder: directed and random packed streams
// are pushed through the slave stream and every decoded word is checked against a predictor.
// Depends on lzss_pkg (result word type, format constants) and lzss_stream_decoder_top.
`timescale 1ns / 1ps

module tb_lzss_stream_decoder_top;

	localparam int unsigned WIN_DEPTH = 4096;
	localparam int unsigned DRAIN_CYCLES = 40;

	// Decoder phases as the predictor tracks them.
	typedef enum logic [1:0] {
		PH_HEADER,
		PH_TOKEN,
		PH_REF_LOW,
		PH_DONE
	} dec_phase_t;

	// One packed byte waiting to be offered, with its pacing controls.
	typedef struct {
		logic [7:0] data_b;
		logic       last;
		logic       hold;   // wait until every pending decoded word has arrived
		logic       calm;   // no gaps and no stalls while this word is current
	} packed_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	packed_item_t          packed_q [$];
	lzss_pkg::out_word_t   decoded_q [$];
	packed_item_t          cur_item;
	lzss_pkg::out_word_t   want;
	logic                  calm_now = 1'b0;
	int unsigned           words_offered = 0;
	int unsigned           words_in = 0;
	int unsigned           errors = 0;

	// Predictor state: a private copy of the decoder.
	logic [7:0]                      hist_win [WIN_DEPTH];
	logic [11:0]                     win_ptr = '0;
	dec_phase_t                      phase = PH_HEADER;
	logic [1:0]                      hdr_idx = '0;
	logic [7:0]                      flag_byte = '0;
	logic [3:0]                      flags_left = '0;
	logic [7:0]                      ref_hi = '0;
	logic [lzss_pkg::COUNT_W-1:0]    remaining = '0;
	logic [lzss_pkg::COUNT_W-1:0]    produced = '0;

	lzss_stream_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	// A new stream starts at the header; the window and its pointer carry over.
	function automatic void restart_stream();
		phase = PH_HEADER;
		hdr_idx = '0;
		flag_byte = '0;
		flags_left = '0;
		ref_hi = '0;
		remaining = '0;
		produced = '0;
	endfunction

	// Appends one decoded byte to the window and to the expected words.
	function automatic void emit_decoded(input logic [7:0] b, ref lzss_pkg::out_word_t res [$]);
		lzss_pkg::out_word_t w;
		hist_win[win_ptr] = b;
		win_ptr = win_ptr + 12'd1;
		remaining = remaining - 1'b1;
		produced = produced + 1'b1;
		w = '{data_b: b, has_data: 1'b1, run_end: 1'b0, finished: 1'b0, total: produced};
		res.push_back(w);
	endfunction

	// Works out every decoded word that one accepted packed byte causes and queues them.
	function automatic void decode_packed_byte(input logic [7:0] b, input logic last);
		lzss_pkg::out_word_t res [$];
		int unsigned         run;
		logic [12:0]         back_dist;
		logic [11:0]         src;
		case (phase)
			PH_HEADER: begin
				if (hdr_idx == lzss_pkg::HDR_LEN_LO)
					remaining = {16'h0000, b};
				else if (hdr_idx == lzss_pkg::HDR_LEN_MID)
					remaining[15:8] = b;
				else if (hdr_idx == lzss_pkg::HDR_LEN_HI)
					remaining[23:16] = b;
				if (hdr_idx == lzss_pkg::HDR_LEN_HI) begin
					hdr_idx = '0;
					flags_left = '0;
					phase = PH_TOKEN;
				end else begin
					hdr_idx = hdr_idx + 2'd1;
				end
			end
			PH_TOKEN: begin
				if (flags_left == 0) begin
					flag_byte = b;
					flags_left = 4'(lzss_pkg::FLAG_BITS);
				end else begin
					flags_left = flags_left - 4'd1;
					if (!flag_byte[flags_left[2:0]]) begin
						emit_decoded(b, res);
					end else begin
						ref_hi = b;
						phase = PH_REF_LOW;
					end
				end
			end
			PH_REF_LOW: begin
				run = int'(ref_hi[7:4]) + lzss_pkg::LEN_BIAS;
				back_dist = {1'b0, ref_hi[3:0], b} + 13'd1;
				if (run > remaining)
					run = remaining;
				for (int unsigned k = 0; k < run; k++) begin
					src = win_ptr - back_dist[11:0];
					emit_decoded(hist_win[src], res);
				end
				phase = PH_TOKEN;
			end
			default: phase = PH_DONE;
		endcase
		if (phase == PH_TOKEN && remaining == 0)
			phase = PH_DONE;
		if (res.size() == 0)
			res.push_back('{data_b: 8'h00, has_data: 1'b0, run_end: 1'b0, finished: 1'b0,
				total: produced});
		res[res.size()-1].run_end = 1'b1;
		res[res.size()-1].finished = (phase == PH_DONE) || last;
		if (last)
			restart_stream();
		foreach (res[i])
			decoded_q.push_back(res[i]);
	endfunction

	function automatic void queue_byte(input logic [7:0] b, input logic last, input logic hold,
	                                   input logic calm);
		packed_item_t it;
		it = '{data_b: b, last: last, hold: hold, calm: calm};
		packed_q.push_back(it);
	endfunction

	// Builds one compressed stream of a given decoded length. Tokens are drawn at random;
	// most back references point inside the bytes already decoded. Junk bytes are appended
	// past the decoded length, the stream is cut after cap bytes, and its last byte is final.
	function automatic void queue_stream(input logic [23:0] len, input int unsigned cap,
	                                     input int unsigned junk, input logic hold,
	                                     input logic calm);
		logic [7:0]  bytes [$];
		logic [7:0]  flags;
		int unsigned rem;
		int unsigned made;
		int unsigned run;
		int unsigned back_dist;
		int          bit_i;
		bytes.push_back(8'($urandom_range(255)));
		bytes.push_back(len[7:0]);
		bytes.push_back(len[15:8]);
		bytes.push_back(len[23:16]);
		rem = len;
		made = 0;
		while (rem != 0 && bytes.size() < cap) begin
			flags = 8'($urandom_range(255));
			bytes.push_back(flags);
			for (bit_i = 7; bit_i >= 0 && rem != 0; bit_i--) begin
				if (!flags[bit_i]) begin
					bytes.push_back(8'($urandom_range(255)));
					rem--;
					made++;
				end else begin
					run = $urandom_range(15);
					if (made != 0 && $urandom_range(99) < 80)
						back_dist = $urandom_range(((made > WIN_DEPTH) ? WIN_DEPTH : made) - 1);
					else
						back_dist = $urandom_range(WIN_DEPTH - 1);
					bytes.push_back({run[3:0], back_dist[11:8]});
					bytes.push_back(back_dist[7:0]);
					run = run + lzss_pkg::LEN_BIAS;
					if (run > rem)
						run = rem;
					rem -= run;
					made += run;
				end
			end
		end
		repeat (junk) bytes.push_back(8'($urandom_range(255)));
		while (bytes.size() > cap)
			void'(bytes.pop_back());
		foreach (bytes[i])
			queue_byte(bytes[i], i == bytes.size() - 1, hold && i == 0, calm);
	endfunction

	// Driver: inputs change only at the falling edge. A word stays on the bus until the
	// monitor has counted its handshake; then valid drops unless a next word is ready.
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			m_tready <= 1'b0;
		end else begin
			if (words_in == words_offered) begin
				if (packed_q.size() != 0
				    && (!packed_q[0].hold || decoded_q.size() == 0)
				    && (packed_q[0].calm || $urandom_range(99) >= 10)) begin
					cur_item = packed_q.pop_front();
					calm_now = cur_item.calm;
					s_tdata  <= cur_item.data_b;
					s_tlast  <= cur_item.last;
					s_tvalid <= 1'b1;
					words_offered++;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= calm_now || ($urandom_range(99) >= 10);
		end
	end

	// Monitor: at each rising edge the decoded word is checked first, then an accepted
	// packed byte is fed to the predictor, so expectations only ever join at the back.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected word: out_byte %02h, has_data %0d, total %0d",
						m_tdata[7:0], m_tuser[0], m_tdata[31:8]);
					errors++;
				end else begin
					want = decoded_q.pop_front();
					if (m_tdata[7:0] !== want.data_b) begin
						$error("out_byte: expected %02h, actual %02h", want.data_b, m_tdata[7:0]);
						errors++;
					end
					if (m_tuser[0] !== want.has_data) begin
						$error("has_data: expected %0d, actual %0d", want.has_data, m_tuser[0]);
						errors++;
					end
					if (m_tlast !== want.run_end) begin
						$error("run_end: expected %0d, actual %0d", want.run_end, m_tlast);
						errors++;
					end
					if (m_tuser[1] !== want.finished) begin
						$error("finished: expected %0d, actual %0d", want.finished, m_tuser[1]);
						errors++;
					end
					if (m_tdata[31:8] !== want.total) begin
						$error("produced_total: expected %0d, actual %0d", want.total,
							m_tdata[31:8]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				decode_packed_byte(s_tdata, s_tlast);
				words_in++;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		int unsigned random_start;
		int unsigned nstream;
		int unsigned pick;
		logic        hold;
		logic        calm;
		foreach (hist_win[i])
			hist_win[i] = 8'h00;

		// Zero decoded length: decoding ends after the header, then two bytes are skipped.
		queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b1, 1'b0, 1'b0);
		// Length 20: a literal, a 3-byte reference reaching 4096 back past the start
		// (zeros), then an 18-byte overlapping copy at distance one, clamped to 16. The
		// length is then reached, so the next byte is skipped up to the final one.
		queue_byte(8'hAA, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h14, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h7F, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h0F, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hF0, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h55, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h00, 1'b1, 1'b0, 1'b0);
		// Largest decoded length, ended on the first byte of a reference, which is dropped.
		queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		queue_byte(8'hFF, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h80, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h3C, 1'b1, 1'b0, 1'b0);
		// A header cut off after two bytes.
		queue_byte(8'h12, 1'b0, 1'b0, 1'b0);
		queue_byte(8'h34, 1'b1, 1'b0, 1'b0);

		// Random part: mostly complete streams, some cut short, some noise. The first
		// random stream waits for the decoder to drain; two streams run without gaps.
		random_start = packed_q.size();
		nstream = 0;
		while (packed_q.size() - random_start < 70) begin
			pick = $urandom_range(9);
			hold = (nstream == 0) || ($urandom_range(3) == 0);
			calm = (nstream == 2) || (nstream == 3);
			if (calm)
				queue_stream(24'($urandom_range(30, 50)), 1000, 0, hold, calm);
			else if (pick <= 6)
				queue_stream(24'($urandom_range(1, 24)), 1000, $urandom_range(2), hold, calm);
			else if (pick == 7)
				queue_stream(24'($urandom_range(24'hFFFFFF)), $urandom_range(1, 20), 0, hold,
					calm);
			else if (pick == 8)
				queue_stream(24'h000000, 1000, $urandom_range(1), hold, calm);
			else begin
				repeat ($urandom_range(1, 6))
					queue_byte(8'($urandom_range(255)), $urandom_range(4) == 0, 1'b0, calm);
				queue_byte(8'($urandom_range(255)), 1'b1, 1'b0, calm);
			end
			nstream++;
		end

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		while (packed_q.size() != 0 || words_in != words_offered)
			@(posedge clk);
		while (decoded_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && decoded_q.size() == 0) begin
			$display("tb_lzss_stream_decoder_top: PASS");
		end else begin
			$display("tb_lzss_stream_decoder_top: FAIL");
		end
		$finish;
	end

	// Run limit, far above the slowest legal run including the window clear after reset.
	initial begin
		#1000000;
		$display("tb_lzss_stream_decoder_top: FAIL");
		$finish;
	end

endmodule
